[hw/rtl/b2da_pkg.sv]
// b2da_pkg: shared types, constants and place-weight tables for the
// binary to decimal ASCII converter. No dependencies.

package b2da_pkg;

	localparam int VALUE_W     = 16;
	localparam int CHAR_W      = 6;
	localparam int DIGIT_W     = 4;
	localparam int DIGIT_COUNT = 5;
	localparam int IDX_W       = 3;
	localparam int THR_W       = 17;
	localparam int Q_DEPTH     = 2;

	localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
	localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(DIGIT_COUNT - 1);

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [IDX_W-1:0]   first;
	} item_t;

	function automatic logic [THR_W-1:0] place_weight(input logic [IDX_W-1:0] idx);
		logic [THR_W-1:0] w;
		case (idx)
			3'd0:    w = THR_W'(10000);
			3'd1:    w = THR_W'(1000);
			3'd2:    w = THR_W'(100);
			3'd3:    w = THR_W'(10);
			default: w = THR_W'(1);
		endcase
		return w;
	endfunction

	// k times the weight of a place
	function automatic logic [THR_W-1:0] threshold(input logic [IDX_W-1:0] idx,
			input logic [DIGIT_W-1:0] k);
		logic [31:0] p;
		p = 32'(place_weight(idx)) * 32'(k);
		return p[THR_W-1:0];
	endfunction

endpackage

[hw/rtl/binary_to_decimal_ascii.sv]
// binary_to_decimal_ascii: 16-bit unsigned to decimal ASCII digits, MSD first.
// The first digit of a value passes the queue, the sequencer's value register and the output register.
// Throughput: one digit per cycle while digit_stall is low; a value takes one step of the
// digit sequencer per decimal digit (1 to 5 digits), so the digit count sets the item rate.
// Reset (arst_n, async low) empties the queue and drops any run in progress.
// Depends on b2da_pkg, b2da_front, b2da_queue, b2da_back.

module binary_to_decimal_ascii import b2da_pkg::*; #(
	parameter int QUEUE_DEPTH = Q_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [VALUE_W-1:0] value,
	output logic               digit_valid,
	input  logic               digit_stall,
	output logic [CHAR_W-1:0]  digit_char,
	output logic               last_digit
);

	item_t front_item;
	item_t head;
	logic  full;
	logic  not_empty;
	logic  pop;

	b2da_front u_front (
		.value (value),
		.item  (front_item)
	);

	b2da_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (item_valid),
		.push_item (front_item),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	assign item_stall = full;

	b2da_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (not_empty),
		.q_item      (head),
		.q_pop       (pop),
		.digit_valid (digit_valid),
		.digit_stall (digit_stall),
		.digit_char  (digit_char),
		.last_digit  (last_digit)
	);

endmodule

[hw/rtl/b2da_front.sv]
// b2da_front: accept side, finds the most significant nonzero place of a value (the units place for zero).
// Depends on b2da_pkg.

module b2da_front import b2da_pkg::*; (
	input  logic [VALUE_W-1:0] value,
	output item_t              item
);

	logic [IDX_W-1:0] first;

	always_comb begin
		first = LAST_IDX;
		for (int i = DIGIT_COUNT - 2; i >= 0; i--) begin
			if ({1'b0, value} >= place_weight(IDX_W'(i))) begin
				first = IDX_W'(i);
			end
		end
		item.value = value;
		item.first = first;
	end

endmodule

[hw/rtl/b2da_queue.sv]
// b2da_queue: short FIFO of classified items between front and back end.
// Depends on b2da_pkg.

module b2da_queue import b2da_pkg::*; #(
	parameter int DEPTH = Q_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  not_empty,
	output item_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t             mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/b2da_back.sv]
// b2da_back: digit sequencer, one decimal place per cycle while the output is not stalled, registered output.
// Depends on b2da_pkg.

module b2da_back import b2da_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  item_t             q_item,
	output logic              q_pop,
	output logic              digit_valid,
	input  logic              digit_stall,
	output logic [CHAR_W-1:0] digit_char,
	output logic              last_digit
);

	logic               busy_q;
	logic [VALUE_W-1:0] v_q;
	logic [IDX_W-1:0]   idx_q;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;

	logic               advance;
	logic               step;
	logic               last_step;
	logic [DIGIT_W-1:0] d;
	logic [THR_W-1:0]   sub;
	logic [VALUE_W-1:0] rem;

	// largest multiple of the place weight not above v
	always_comb begin
		d   = '0;
		sub = '0;
		for (int k = 1; k <= 9; k++) begin
			if ({1'b0, v_q} >= threshold(idx_q, DIGIT_W'(k))) begin
				d   = DIGIT_W'(k);
				sub = threshold(idx_q, DIGIT_W'(k));
			end
		end
		rem = v_q - sub[VALUE_W-1:0];
	end

	assign advance   = !out_valid_q || !digit_stall;
	assign step      = busy_q && advance;
	assign last_step = step && (idx_q == LAST_IDX);
	assign q_pop     = q_valid && (!busy_q || last_step);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
			end else if (last_step) begin
				busy_q <= 1'b0;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (advance) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			v_q   <= q_item.value;
			idx_q <= q_item.first;
		end else if (step) begin
			v_q   <= rem;
			idx_q <= idx_q + 1'b1;
		end
		if (step) begin
			char_q <= ASCII_ZERO + CHAR_W'(d);
			last_q <= (idx_q == LAST_IDX);
		end
	end

	assign digit_valid = out_valid_q;
	assign digit_char  = char_q;
	assign last_digit  = last_q;

endmodule

[hw/rtl/b2da_checker.sv]
// b2da_checker: port-level checks on the value input and the digit stream, bound to the top level.
// Depends on b2da_pkg.

module b2da_checker import b2da_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_stall,
	input logic [VALUE_W-1:0] value,
	input logic               digit_valid,
	input logic               digit_stall,
	input logic [CHAR_W-1:0]  digit_char,
	input logic               last_digit
);

	logic             first_q;
	logic [IDX_W-1:0] cnt_q;
	logic             beat;

	assign beat = digit_valid && !digit_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			cnt_q   <= '0;
		end else if (beat) begin
			first_q <= last_digit;
			cnt_q   <= last_digit ? '0 : cnt_q + 1'b1;
		end
	end

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(value))
		else $error("stalled value beat changed");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid |-> (digit_char >= ASCII_ZERO) && (digit_char <= ASCII_ZERO + CHAR_W'(9)))
		else $error("digit out of range");

	a_no_leading_zero: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid && first_q && (digit_char == ASCII_ZERO) |-> last_digit)
		else $error("leading zero");

	a_run_length: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid && (cnt_q == LAST_IDX) |-> last_digit)
		else $error("run longer than five digits");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid && digit_stall |=>
			digit_valid && $stable(digit_char) && $stable(last_digit))
		else $error("stalled beat changed");

endmodule

bind binary_to_decimal_ascii b2da_checker u_chk (.*);

[test/binary_to_decimal_ascii_tb.sv]
// binary_to_decimal_ascii_tb: self-checking bench for the 16-bit binary to decimal ASCII
// converter. Directed and random values, random idling on both sides, digit-by-digit check.
// Depends on b2da_pkg and binary_to_decimal_ascii.

module binary_to_decimal_ascii_tb import b2da_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 250;

	typedef struct {
		logic [VALUE_W-1:0] value;
		int                 gap;
		bit                 drain;
	} pending_value_t;

	typedef struct {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} digit_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic [VALUE_W-1:0] value = '0;
	logic               digit_valid;
	logic               digit_stall = 1'b0;
	logic [CHAR_W-1:0]  digit_char;
	logic               last_digit;

	pending_value_t values_to_send[$];
	digit_t         expected_digits[$];

	int  queued_total = 0;
	int  values_sent = 0;
	int  predicted_total = 0;
	int  checked_total = 0;
	int  gap_count = 0;
	int  rx_wait = 0;
	int  quiet = 0;
	int  mismatches = 0;
	logic rx_hold = 1'b0;

	binary_to_decimal_ascii uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.value      (value),
		.digit_valid(digit_valid),
		.digit_stall(digit_stall),
		.digit_char (digit_char),
		.last_digit (last_digit)
	);

	always #5 clk = ~clk;

	// Expected characters for one value, most significant first, no leading zeros.
	function automatic int predict_digits(input logic [VALUE_W-1:0] v);
		int unsigned rest;
		int unsigned weight;
		int unsigned d;
		int          pos;
		int          n;
		bit          started;
		digit_t      dg;
		rest = v;
		weight = 10000;
		started = 0;
		n = 0;
		for (pos = 0; pos < DIGIT_COUNT; pos++) begin
			d = rest / weight;
			rest = rest % weight;
			if (d != 0 || started || pos == DIGIT_COUNT - 1) begin
				started = 1;
				dg.ch = ASCII_ZERO + CHAR_W'(d);
				dg.last = (pos == DIGIT_COUNT - 1);
				expected_digits.push_back(dg);
				n++;
			end
			weight = weight / 10;
		end
		return n;
	endfunction

	function automatic void note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("MISMATCH: %s", msg);
	endfunction

	function automatic int draw_wait(input int idx);
		if ((idx / 40) % 3 == 1)
			return 0;
		if ($urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	function automatic void queue_value(input logic [VALUE_W-1:0] v, input int gap,
			input bit drain);
		pending_value_t p;
		p.value = v;
		p.gap = gap;
		p.drain = drain;
		values_to_send.push_back(p);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin : value_driver
		pending_value_t head;
		logic offer;
		int   n;
		int   owed;
		if (!arst_n) begin
			item_valid <= 1'b0;
			value <= '0;
			gap_count <= 0;
		end else begin
			offer = item_valid;
			n = 0;
			if (item_valid && !item_stall) begin
				n = predict_digits(value);
				predicted_total <= predicted_total + n;
				values_sent <= values_sent + 1;
				offer = 1'b0;
			end
			owed = predicted_total + n - checked_total;
			if (!offer && values_to_send.size() != 0) begin
				head = values_to_send[0];
				if (head.drain && owed > 0) begin
					gap_count <= 0;
				end else if (gap_count < head.gap) begin
					gap_count <= gap_count + 1;
				end else begin
					void'(values_to_send.pop_front());
					value <= head.value;
					offer = 1'b1;
					gap_count <= 0;
				end
			end
			item_valid <= offer;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin : digit_monitor
		digit_t want;
		int     wait_n;
		if (!arst_n) begin
			digit_stall <= 1'b0;
			rx_wait <= 0;
			checked_total <= 0;
		end else begin
			wait_n = (rx_wait > 0) ? rx_wait - 1 : 0;
			if (digit_valid && !digit_stall) begin
				checked_total <= checked_total + 1;
				if (expected_digits.size() == 0) begin
					note_mismatch($sformatf("unexpected digit char=%0d last=%0b",
						digit_char, last_digit));
				end else begin
					want = expected_digits.pop_front();
					if (digit_char !== want.ch || last_digit !== want.last)
						note_mismatch($sformatf("char exp %0d got %0d, last exp %0b got %0b",
							want.ch, digit_char, want.last, last_digit));
				end
				wait_n = draw_wait(checked_total);
			end
			rx_wait <= wait_n;
			digit_stall <= rx_hold || wait_n != 0;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (digit_valid && !digit_stall)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// long receiver hold-off so the block backs up into its input
	initial begin
		while (values_sent < 40)
			@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		int i;
		int mag;
		logic [VALUE_W-1:0] v;
		queue_value(16'd0, 0, 0);
		queue_value(16'd1, 0, 0);
		queue_value(16'd9, 1, 0);
		queue_value(16'd10, 0, 0);
		queue_value(16'd11, 3, 0);
		queue_value(16'd90, 0, 0);
		queue_value(16'd99, 0, 0);
		queue_value(16'd100, 2, 0);
		queue_value(16'd101, 0, 0);
		queue_value(16'd999, 0, 0);
		queue_value(16'd1000, 5, 0);
		queue_value(16'd1009, 0, 0);
		queue_value(16'd9999, 0, 0);
		queue_value(16'd10000, 0, 0);
		queue_value(16'd10001, 1, 0);
		queue_value(16'd12345, 0, 0);
		queue_value(16'd32768, 0, 0);
		queue_value(16'd40000, 0, 0);
		queue_value(16'd43690, 0, 0);
		queue_value(16'd21845, 0, 0);
		queue_value(16'd50505, 0, 0);
		queue_value(16'd65534, 0, 0);
		queue_value(16'd65535, 0, 0);
		for (i = 0; i < 107; i++) begin
			mag = $urandom_range(0, 5);
			case (mag)
				0:       v = VALUE_W'($urandom_range(0, 9));
				1:       v = VALUE_W'($urandom_range(10, 99));
				2:       v = VALUE_W'($urandom_range(100, 999));
				3:       v = VALUE_W'($urandom_range(1000, 9999));
				4:       v = VALUE_W'($urandom_range(10000, 65535));
				default: v = VALUE_W'($urandom);
			endcase
			queue_value(v, (i >= 80 && i < 105) ? 0 : draw_wait(i), i == 0 || i == 60);
		end
		queued_total = values_to_send.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (values_sent < queued_total)
			@(posedge clk);
		while (checked_total < predicted_total)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (expected_digits.size() != 0)
			note_mismatch($sformatf("%0d expected digits never arrived",
				expected_digits.size()));
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
